FILE: hdl/cpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_pkg
// types, constants and the arctangent table shared by the converter modules
// ----------------------------------------------------------------------------
package cpc_pkg;

    // datapath widths
    localparam int XY_W   = 52;   // vector components, units of 2^-32
    localparam int Z_W    = 36;   // angle accumulator, units of 2^-30
    localparam int R_W    = 33;   // radius after optional negation
    localparam int XR_W   = 35;   // rounded magnitude before gain
    localparam int GAIN_W = 30;
    localparam int PROD_W = XR_W + GAIN_W;
    localparam int TABLE_LEN = 30;

    // operation codes
    localparam logic [1:0] KIND_POLAR = 2'd0;
    localparam logic [1:0] KIND_RECT  = 2'd1;
    localparam logic [1:0] KIND_UNIT  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // fixed constants
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
    localparam logic signed [Z_W-1:0] PI30      = 36'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI30 = 36'sd1686629713;
    localparam logic signed [33:0]    PI29_IN   = 34'sd1686629713;
    localparam logic signed [33:0]    PI30_IN   = 34'sd3373259426;
    localparam logic signed [34:0]    PI29_OUT  = 35'sd1686629713;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] first_operand;
        logic signed [31:0] second_operand;
    } cpc_in_t;

    typedef struct packed {
        logic signed [31:0] first_result;
        logic signed [31:0] second_result;
        logic               saturated;
    } cpc_out_t;

    // one request in flight through the rotation pipeline
    typedef struct packed {
        logic                   vec;       // vectoring (rect to polar)
        logic                   zero_out;  // origin or unused kind
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } lane_t;

    // atan(2^-idx) in units of 2^-30
    function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 36'sh03243F6A8;
            1:  v = 36'sh01DAC6705;
            2:  v = 36'sh00FADBAFC;
            3:  v = 36'sh007F56EA6;
            4:  v = 36'sh003FEAB76;
            5:  v = 36'sh001FFD55B;
            6:  v = 36'sh000FFFAAA;
            7:  v = 36'sh0007FFF55;
            8:  v = 36'sh0003FFFEA;
            9:  v = 36'sh0001FFFFD;
            10: v = 36'sh000100000;
            11: v = 36'sh000080000;
            12: v = 36'sh000040000;
            13: v = 36'sh000020000;
            14: v = 36'sh000010000;
            15: v = 36'sh000008000;
            16: v = 36'sh000004000;
            17: v = 36'sh000002000;
            18: v = 36'sh000001000;
            19: v = 36'sh000000800;
            20: v = 36'sh000000400;
            21: v = 36'sh000000200;
            22: v = 36'sh000000100;
            23: v = 36'sh000000080;
            24: v = 36'sh000000040;
            25: v = 36'sh000000020;
            26: v = 36'sh000000010;
            27: v = 36'sh000000008;
            28: v = 36'sh000000004;
            29: v = 36'sh000000002;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/cpc_rotator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_rotator
// one registered micro-rotation of the cordic pipeline
// ----------------------------------------------------------------------------
module cpc_rotator #(
    parameter int STAGE = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  cpc_pkg::lane_t lane_in,
    output logic           out_valid,
    output cpc_pkg::lane_t lane_out
);

    logic                            valid_reg;
    cpc_pkg::lane_t                  lane_reg;
    cpc_pkg::lane_t                  lane_next;
    logic                            ccw;
    logic signed [cpc_pkg::XY_W-1:0] xs;
    logic signed [cpc_pkg::XY_W-1:0] ys;
    logic signed [cpc_pkg::Z_W-1:0]  at;

    always_comb begin
        // rotation drives z to zero, vectoring drives y to zero
        ccw = lane_in.vec ? (lane_in.y <= 0) : (lane_in.z >= 0);
        xs  = lane_in.x >>> STAGE;
        ys  = lane_in.y >>> STAGE;
        at  = cpc_pkg::atan_entry(STAGE);
        lane_next = lane_in;
        if (ccw) begin
            lane_next.x = lane_in.x - ys;
            lane_next.y = lane_in.y + xs;
            lane_next.z = lane_in.z - at;
        end else begin
            lane_next.x = lane_in.x + ys;
            lane_next.y = lane_in.y - xs;
            lane_next.z = lane_in.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign lane_out  = lane_reg;

endmodule

FILE: hdl/cartesian_polar_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_polar_converter_unit
// pipelined cordic converter between rectangular and polar form
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one request per cycle: kind, first and second operand.
//   kind 0 gives magnitude and atan2 angle of (x, y), kind 1 gives
//   radius*cos and radius*sin of an angle, kind 2 the unit vector of an
//   angle, kind 3 returns zeros.
//   m_ channel returns one result per request, in request order.
// stages: angle reduction, gain multiply, one stage per micro-rotation,
//   rounding/clamp, magnitude multiply, output register; the first of
//   these loads at the accepting edge.
// throughput: one request per cycle; every stage is a register.
// stall: the whole pipeline holds while the output register is full and
//   m_ready is low, so s_ready follows the output register; nothing is
//   dropped or repeated.
// reset: aresetn (synchronous, active low) clears every valid bit, the
//   pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
module cartesian_polar_converter_unit #(
    parameter int ITERATIONS = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cpc_pkg::cpc_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cpc_pkg::cpc_out_t m_data
);

    localparam int XY_W   = cpc_pkg::XY_W;
    localparam int Z_W    = cpc_pkg::Z_W;
    localparam int R_W    = cpc_pkg::R_W;
    localparam int XR_W   = cpc_pkg::XR_W;
    localparam int PROD_W = cpc_pkg::PROD_W;
    // rounded components are 36 bits after the shift by 16
    localparam int RND_W  = XY_W - 16;
    localparam logic signed [RND_W-1:0] MAX32 = RND_W'(64'sd2147483647);
    localparam logic signed [RND_W-1:0] MIN32 = -RND_W'(64'sd2147483648);
    localparam logic [PROD_W:0]         MAG_HALF = (PROD_W+1)'(64'd536870912);
    localparam logic [PROD_W-30:0]      MAG_MAX  = (PROD_W-29)'(64'h7FFFFFFF);

    // whole pipeline advances together when the output register can move
    logic adv;
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ------------------------------------------------------------------
    // stage a: kind decode, quadrant folding and angle reduction
    // ------------------------------------------------------------------
    logic                   pre_valid_reg;
    cpc_pkg::lane_t         pre_reg;
    cpc_pkg::lane_t         pre_next;
    logic signed [XY_W-1:0] xin_ext;
    logic signed [XY_W-1:0] yin_ext;
    logic signed [33:0]     ang_in;
    logic signed [33:0]     ang_red;
    logic signed [Z_W-1:0]  z_rot;
    logic signed [R_W-1:0]  r_sel;
    logic signed [R_W-1:0]  r_eff;

    always_comb begin
        xin_ext = {{(XY_W-48){s_data.first_operand[31]}}, s_data.first_operand, 16'b0};
        yin_ext = {{(XY_W-48){s_data.second_operand[31]}}, s_data.second_operand, 16'b0};

        // angle input folded once into [-pi, pi]
        ang_in = {{2{s_data.second_operand[31]}}, s_data.second_operand};
        if (ang_in > cpc_pkg::PI29_IN) begin
            ang_red = ang_in - cpc_pkg::PI30_IN;
        end else if (ang_in < -cpc_pkg::PI29_IN) begin
            ang_red = ang_in + cpc_pkg::PI30_IN;
        end else begin
            ang_red = ang_in;
        end

        if (s_data.kind == cpc_pkg::KIND_UNIT) begin
            r_sel = R_W'(33'sd65536);
        end else begin
            r_sel = {s_data.first_operand[31], s_data.first_operand};
        end

        // past pi/2: turn by pi and flip the radius
        z_rot = {{(Z_W-35){ang_red[33]}}, ang_red, 1'b0};
        r_eff = r_sel;
        if (z_rot > cpc_pkg::HALF_PI30) begin
            z_rot = z_rot - cpc_pkg::PI30;
            r_eff = -r_sel;
        end else if (z_rot < -cpc_pkg::HALF_PI30) begin
            z_rot = z_rot + cpc_pkg::PI30;
            r_eff = -r_sel;
        end

        pre_next = '0;
        unique case (s_data.kind) inside
            cpc_pkg::KIND_POLAR: begin
                pre_next.vec      = 1'b1;
                pre_next.zero_out = (s_data.first_operand == 32'sd0)
                                 && (s_data.second_operand == 32'sd0);
                if (s_data.first_operand < 0) begin
                    // left half plane: turn by pi first
                    pre_next.x = -xin_ext;
                    pre_next.y = -yin_ext;
                    pre_next.z = (s_data.second_operand >= 0) ? cpc_pkg::PI30
                                                              : -cpc_pkg::PI30;
                end else begin
                    pre_next.x = xin_ext;
                    pre_next.y = yin_ext;
                    pre_next.z = '0;
                end
            end
            cpc_pkg::KIND_RECT, cpc_pkg::KIND_UNIT: begin
                // radius rides in x until the gain stage
                pre_next.x = {{(XY_W-R_W){r_eff[R_W-1]}}, r_eff};
                pre_next.z = z_rot;
            end
            default: begin
                pre_next.zero_out = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (adv) begin
            pre_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pre_reg <= pre_next;
        end
    end

    // ------------------------------------------------------------------
    // stage b: pre-scale the radius by the cordic gain
    // ------------------------------------------------------------------
    logic               gain_valid_reg;
    cpc_pkg::lane_t     gain_reg;
    cpc_pkg::lane_t     gain_next;
    logic signed [63:0] gain_prod;
    logic signed [63:0] gain_sum;

    always_comb begin
        gain_prod = $signed(pre_reg.x[R_W-1:0]) * $signed({1'b0, cpc_pkg::GAIN_Q30});
        gain_sum  = gain_prod + 64'sd8192;
        gain_next = pre_reg;
        if (!pre_reg.vec) begin
            gain_next.x = XY_W'(gain_sum >>> 14);
            gain_next.y = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_valid_reg <= 1'b0;
        end else if (adv) begin
            gain_valid_reg <= pre_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            gain_reg <= gain_next;
        end
    end

    // ------------------------------------------------------------------
    // micro-rotation stages, one per iteration
    // ------------------------------------------------------------------
    cpc_pkg::lane_t        chain [ITERATIONS+1];
    logic [ITERATIONS:0]   chain_valid;

    assign chain[0]       = gain_reg;
    assign chain_valid[0] = gain_valid_reg;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_rot
        cpc_rotator #(
            .STAGE (g)
        ) u_rot (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (chain_valid[g]),
            .lane_in   (chain[g]),
            .out_valid (chain_valid[g+1]),
            .lane_out  (chain[g+1])
        );
    end

    // ------------------------------------------------------------------
    // stage c: rounding, component clamp, angle clamp
    // ------------------------------------------------------------------
    cpc_pkg::lane_t          fin;
    logic signed [XY_W-1:0]  x_rnd;
    logic signed [XY_W-1:0]  y_rnd;
    logic signed [RND_W-1:0] x_sh;
    logic signed [RND_W-1:0] y_sh;
    logic signed [Z_W-1:0]   z_rnd;
    logic signed [Z_W-2:0]   ang;

    logic                    p1_valid_reg;
    logic                    p1_vec_reg,  p1_vec_next;
    logic                    p1_zero_reg, p1_zero_next;
    logic [XR_W-1:0]         p1_xr_reg,   p1_xr_next;
    logic signed [31:0]      p1_r0_reg,   p1_r0_next;
    logic signed [31:0]      p1_r1_reg,   p1_r1_next;
    logic                    p1_sat_reg,  p1_sat_next;

    assign fin = chain[ITERATIONS];

    always_comb begin
        x_rnd = fin.x + XY_W'(64'sd32768);
        y_rnd = fin.y + XY_W'(64'sd32768);
        x_sh  = $signed(x_rnd[XY_W-1:16]);
        y_sh  = $signed(y_rnd[XY_W-1:16]);
        z_rnd = fin.z + Z_W'(64'sd1);
        ang   = $signed(z_rnd[Z_W-1:1]);

        p1_vec_next  = fin.vec;
        p1_zero_next = fin.zero_out;
        // magnitude is non-negative after vectoring
        p1_xr_next   = x_rnd[XR_W+15:16];
        p1_sat_next  = 1'b0;

        if (fin.vec) begin
            p1_r0_next = '0;
            if (ang > cpc_pkg::PI29_OUT) begin
                p1_r1_next = cpc_pkg::PI29_OUT[31:0];
            end else if (ang < -cpc_pkg::PI29_OUT) begin
                p1_r1_next = -cpc_pkg::PI29_OUT[31:0];
            end else begin
                p1_r1_next = ang[31:0];
            end
        end else begin
            if (x_sh > MAX32) begin
                p1_r0_next  = MAX32[31:0];
                p1_sat_next = 1'b1;
            end else if (x_sh < MIN32) begin
                p1_r0_next  = MIN32[31:0];
                p1_sat_next = 1'b1;
            end else begin
                p1_r0_next  = x_sh[31:0];
            end
            if (y_sh > MAX32) begin
                p1_r1_next  = MAX32[31:0];
                p1_sat_next = 1'b1;
            end else if (y_sh < MIN32) begin
                p1_r1_next  = MIN32[31:0];
                p1_sat_next = 1'b1;
            end else begin
                p1_r1_next  = y_sh[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= chain_valid[ITERATIONS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_vec_reg  <= p1_vec_next;
            p1_zero_reg <= p1_zero_next;
            p1_xr_reg   <= p1_xr_next;
            p1_r0_reg   <= p1_r0_next;
            p1_r1_reg   <= p1_r1_next;
            p1_sat_reg  <= p1_sat_next;
        end
    end

    // ------------------------------------------------------------------
    // stage d: magnitude gain correction
    // ------------------------------------------------------------------
    logic               p2_valid_reg;
    logic [PROD_W-1:0]  p2_prod_reg, p2_prod_next;
    logic               p2_vec_reg;
    logic               p2_zero_reg;
    logic signed [31:0] p2_r0_reg;
    logic signed [31:0] p2_r1_reg;
    logic               p2_sat_reg;

    assign p2_prod_next = PROD_W'(p1_xr_reg) * PROD_W'(cpc_pkg::GAIN_Q30);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_prod_reg <= p2_prod_next;
            p2_vec_reg  <= p1_vec_reg;
            p2_zero_reg <= p1_zero_reg;
            p2_r0_reg   <= p1_r0_reg;
            p2_r1_reg   <= p1_r1_reg;
            p2_sat_reg  <= p1_sat_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage e: magnitude rounding and saturation, output register
    // ------------------------------------------------------------------
    logic [PROD_W:0]    mag_sum;
    logic [PROD_W-30:0] mag_q;
    cpc_pkg::cpc_out_t  out_reg, out_next;

    always_comb begin
        mag_sum  = {1'b0, p2_prod_reg} + MAG_HALF;
        mag_q    = mag_sum[PROD_W:30];
        out_next = '0;
        if (p2_zero_reg) begin
            out_next = '0;
        end else if (p2_vec_reg) begin
            if (mag_q > MAG_MAX) begin
                out_next.first_result = MAG_MAX[31:0];
                out_next.saturated    = 1'b1;
            end else begin
                out_next.first_result = mag_q[31:0];
            end
            out_next.second_result = p2_r1_reg;
        end else begin
            out_next.first_result  = p2_r0_reg;
            out_next.second_result = p2_r1_reg;
            out_next.saturated     = p2_sat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: test/cartesian_polar_converter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_polar_converter_unit_test
// self-checking bench for the cordic cartesian/polar converter
// ----------------------------------------------------------------------------
// every accepted request is run through a bit-exact cordic model in the
// bench and the expected result is queued; results leaving the m_ channel
// are checked in order, field by field. a directed burst covers the corner
// cases, then random requests follow with random stalls on both channels.
// ----------------------------------------------------------------------------

class conversion_scoreboard #(int ROTATIONS = 24);

    localparam int     STEPS      = (ROTATIONS < 30) ? ROTATIONS : 30;
    localparam longint GAIN       = 64'sd652032874;
    localparam longint PI_Q29     = 64'sd1686629713;
    localparam longint PI_Q30     = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q16    = 64'sd65536;
    localparam longint MAX_S32    = 64'sd2147483647;
    localparam longint MIN_S32    = -64'sd2147483648;

    // atan(2^-i), units of 2^-30
    localparam longint ARCTAN [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h00100000, 64'h00080000, 64'h00040000, 64'h00020000, 64'h00010000,
        64'h00008000, 64'h00004000, 64'h00002000, 64'h00001000, 64'h00000800,
        64'h00000400, 64'h00000200, 64'h00000100, 64'h00000080, 64'h00000040,
        64'h00000020, 64'h00000010, 64'h00000008, 64'h00000004, 64'h00000002
    };

    cpc_pkg::cpc_out_t awaited_conversions[$];
    int                errors;

    function new();
        errors = 0;
    endfunction

    // vectoring: magnitude and atan2 of (x, y)
    function cpc_pkg::cpc_out_t polar_of(longint xi, longint yi);
        cpc_pkg::cpc_out_t res;
        longint            x, y, z, dx, dy, ang;
        longint unsigned   xr, mag;
        res = '0;
        if (xi == 0 && yi == 0) return res;
        x = xi * 65536;
        y = yi * 65536;
        z = 0;
        // left half plane: turn by pi first
        if (xi < 0) begin
            x = -x;
            y = -y;
            z = (yi >= 0) ? PI_Q30 : -PI_Q30;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN[i];
            end
        end
        xr  = (longint'(x) + 64'd32768) >> 16;
        mag = (xr * 64'd652032874 + 64'd536870912) >> 30;
        if (mag > 64'h7FFF_FFFF) begin
            mag = 64'h7FFF_FFFF;
            res.saturated = 1'b1;
        end
        ang = (z + 1) >>> 1;
        if (ang > PI_Q29) ang = PI_Q29;
        if (ang < -PI_Q29) ang = -PI_Q29;
        res.first_result  = mag[31:0];
        res.second_result = ang[31:0];
        return res;
    endfunction

    // rotation: r*cos(a), r*sin(a) with a in q3.29
    function cpc_pkg::cpc_out_t rect_of(longint r, longint a);
        cpc_pkg::cpc_out_t res;
        longint            x, y, z, dx, dy, xs, ys;
        res = '0;
        if (a > PI_Q29) a = a - PI_Q30;
        if (a < -PI_Q29) a = a + PI_Q30;
        z = a * 2;
        // keep the cordic within +-pi/2
        if (z > HALF_PI_Q30) begin
            z = z - PI_Q30;
            r = -r;
        end else if (z < -HALF_PI_Q30) begin
            z = z + PI_Q30;
            r = -r;
        end
        x = (r * GAIN + 8192) >>> 14;
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN[i];
            end
        end
        xs = (x + 32768) >>> 16;
        ys = (y + 32768) >>> 16;
        if (xs > MAX_S32) begin xs = MAX_S32; res.saturated = 1'b1; end
        if (xs < MIN_S32) begin xs = MIN_S32; res.saturated = 1'b1; end
        if (ys > MAX_S32) begin ys = MAX_S32; res.saturated = 1'b1; end
        if (ys < MIN_S32) begin ys = MIN_S32; res.saturated = 1'b1; end
        res.first_result  = xs[31:0];
        res.second_result = ys[31:0];
        return res;
    endfunction

    function cpc_pkg::cpc_out_t convert_request(cpc_pkg::cpc_in_t req);
        longint a, b;
        a = req.first_operand;
        b = req.second_operand;
        case (req.kind)
            cpc_pkg::KIND_POLAR: return polar_of(a, b);
            cpc_pkg::KIND_RECT:  return rect_of(a, b);
            cpc_pkg::KIND_UNIT:  return rect_of(ONE_Q16, b);
            default:             return '0;
        endcase
    endfunction

    function void note_request(cpc_pkg::cpc_in_t req);
        awaited_conversions.push_back(convert_request(req));
    endfunction

    function void flag(string what, longint want, longint got);
        errors++;
        $error("%s expected %0d actual %0d", what, want, got);
    endfunction

    function void check_result(cpc_pkg::cpc_out_t got);
        cpc_pkg::cpc_out_t want;
        if (awaited_conversions.size() == 0) begin
            errors++;
            $error("result with no request pending: %h", got);
            return;
        end
        want = awaited_conversions.pop_front();
        if (got.first_result !== want.first_result)
            flag("first_result", want.first_result, got.first_result);
        if (got.second_result !== want.second_result)
            flag("second_result", want.second_result, got.second_result);
        if (got.saturated !== want.saturated)
            flag("saturated", want.saturated, got.saturated);
    endfunction

    function int pending();
        return awaited_conversions.size();
    endfunction

endclass

module cartesian_polar_converter_unit_test;

    localparam int     ROTATIONS    = 24;
    localparam int     RANDOM_ITEMS = 1525;
    localparam int     CALM_ITEMS   = 150;   // tail of the run with no stalls
    localparam int     DRAIN_CYCLES = ROTATIONS + 16;
    localparam int     STALL_LIMIT  = 2000;
    localparam longint PI_Q29       = 64'sd1686629713;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    cpc_pkg::cpc_in_t   s_data;
    logic               m_valid;
    logic               m_ready;
    cpc_pkg::cpc_out_t  m_data;

    // set for the last part of the run: both sides stream without gaps
    logic      calm;

    conversion_scoreboard #(ROTATIONS) board;

    cartesian_polar_converter_unit #(
        .ITERATIONS(ROTATIONS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // sample both handshakes at the rising edge; requests are noted first
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_request(s_data);
            if (m_valid && m_ready) board.check_result(m_data);
        end
    end

    // watchdog: ends the run if neither channel moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side back-pressure: random bursts of stalled cycles
    initial begin : result_backpressure
        int hold;
        hold    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (calm) begin
                m_ready = 1'b1;
            end else if (hold > 0) begin
                hold--;
                m_ready = 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                hold    = $urandom_range(0, 10);
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // present one request at the falling edge and hold it until accepted;
    // outside the calm tail a random idle burst may come first
    task automatic send_request(input logic [1:0] kind, input logic [31:0] a,
                                input logic [31:0] b);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_data.kind           = kind;
        s_data.first_operand  = a;
        s_data.second_operand = b;
        s_valid               = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // hold the sender off until every outstanding request has returned
    task automatic drain_results();
        s_valid = 1'b0;
        while (board.pending() != 0) @(negedge aclk);
    endtask

    // coordinate or radius in q16.16: full range, small values, or an extreme
    function automatic logic [31:0] pick_coord();
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return v;
            4, 5, 6:    return {{11{v[20]}}, v[20:0]};   // within +-16.0
            7:          return {{27{v[4]}}, v[4:0]};     // a few lsbs
            default: begin
                case (v[2:0])
                    3'd0:    return 32'h7FFF_FFFF;
                    3'd1:    return 32'h8000_0000;
                    3'd2:    return 32'h0000_0000;
                    3'd3:    return 32'h0001_0000;
                    3'd4:    return 32'hFFFF_0000;
                    3'd5:    return 32'hFFFF_FFFF;
                    3'd6:    return 32'h7FFF_0000;
                    default: return 32'h8000_0001;
                endcase
            end
        endcase
    endfunction

    // angle in q3.29: inside +-pi, anywhere, or close to a fold point
    function automatic logic [31:0] pick_angle();
        longint a;
        longint fold;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: a = longint'($urandom_range(0, 32'd3373259426)) - PI_Q29;
            5, 6, 7:       a = longint'($urandom());
            default: begin
                case ($urandom_range(0, 4))
                    0:       fold = PI_Q29;
                    1:       fold = -PI_Q29;
                    2:       fold = PI_Q29 / 2;
                    3:       fold = -(PI_Q29 / 2);
                    default: fold = 0;
                endcase
                a = fold + longint'($urandom_range(0, 64)) - 32;
            end
        endcase
        return a[31:0];
    endfunction

    initial begin : stimulus
        int          pick;
        logic [1:0]  kind;
        board   = new();
        calm    = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // directed corners, vectoring: origin, axes, left half plane,
        // magnitude overflow and the most negative inputs
        send_request(cpc_pkg::KIND_POLAR, 32'h0000_0000, 32'h0000_0000);
        send_request(cpc_pkg::KIND_POLAR, 32'h0001_0000, 32'h0000_0000);
        send_request(cpc_pkg::KIND_POLAR, 32'hFFFF_0000, 32'h0000_0000);
        send_request(cpc_pkg::KIND_POLAR, 32'hFFFF_0000, 32'h0001_0000);
        send_request(cpc_pkg::KIND_POLAR, 32'hFFFF_0000, 32'hFFFF_0000);
        send_request(cpc_pkg::KIND_POLAR, 32'h0000_0000, 32'h0001_0000);
        send_request(cpc_pkg::KIND_POLAR, 32'h0000_0000, 32'hFFFF_0000);
        send_request(cpc_pkg::KIND_POLAR, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(cpc_pkg::KIND_POLAR, 32'h8000_0000, 32'h8000_0000);
        send_request(cpc_pkg::KIND_POLAR, 32'h8000_0000, 32'h7FFF_FFFF);
        // rotation: zero angle, component overflow, angles past pi and pi/2
        send_request(cpc_pkg::KIND_RECT, 32'h0001_0000, 32'h0000_0000);
        send_request(cpc_pkg::KIND_RECT, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(cpc_pkg::KIND_RECT, 32'h8000_0000, PI_Q29[31:0]);
        send_request(cpc_pkg::KIND_RECT, 32'h0001_0000, 32'h7FFF_FFFF);
        send_request(cpc_pkg::KIND_RECT, 32'h0001_0000, 32'h8000_0000);
        send_request(cpc_pkg::KIND_RECT, 32'h0001_0000, 32'd843314857);
        send_request(cpc_pkg::KIND_RECT, 32'h0001_0000, -32'sd843314857);
        send_request(cpc_pkg::KIND_RECT, 32'hFFFF_0000, -PI_Q29[31:0]);
        // unit vector: the first operand must be ignored
        send_request(cpc_pkg::KIND_UNIT, $urandom(), 32'h0000_0000);
        send_request(cpc_pkg::KIND_UNIT, $urandom(), PI_Q29[31:0]);
        send_request(cpc_pkg::KIND_UNIT, $urandom(), -PI_Q29[31:0]);
        send_request(cpc_pkg::KIND_UNIT, 32'h7FFF_FFFF, 32'd843314856);
        // unused kind returns zeros
        send_request(cpc_pkg::KIND_NONE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(cpc_pkg::KIND_NONE, $urandom(), $urandom());

        // let the pipeline run dry once before the random part
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) drain_results();
            if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 40)      kind = cpc_pkg::KIND_POLAR;
            else if (pick < 70) kind = cpc_pkg::KIND_RECT;
            else if (pick < 92) kind = cpc_pkg::KIND_UNIT;
            else                kind = cpc_pkg::KIND_NONE;
            case (kind)
                cpc_pkg::KIND_POLAR: send_request(kind, pick_coord(), pick_coord());
                cpc_pkg::KIND_RECT:  send_request(kind, pick_coord(), pick_angle());
                default:             send_request(kind, $urandom(), pick_angle());
            endcase
        end

        // wait out everything in flight, then watch for stray results
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
